// ===== rtl/pidc_pkg.sv =====
// shared types and constants for the clamped pid controller
package pidc_pkg;

	// fixed field widths
	localparam int DATA_W     = 16;
	localparam int GAIN_W     = 16;
	localparam int LIMIT_W    = 15;
	localparam int GATE_W     = 16;
	localparam int ERR_W      = DATA_W + 1;
	localparam int DERR_W     = ERR_W + 1;
	localparam int PROD_W     = GAIN_W + ERR_W;
	localparam int DPROD_W    = GAIN_W + DERR_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// command codes
	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P         = 3'd0,
		REG_GAIN_I         = 3'd1,
		REG_GAIN_D         = 3'd2,
		REG_INTEGRAL_LIMIT = 3'd3,
		REG_OUTPUT_LIMIT   = 3'd4,
		REG_ERROR_GATE     = 3'd5
	} reg_idx_t;

	// request item
	typedef struct packed {
		logic                     cmd;
		logic signed [DATA_W-1:0] measured;
		logic signed [DATA_W-1:0] target;
	} pidc_req_t;

	// result item
	typedef struct packed {
		logic signed [DATA_W-1:0] drive;
		logic                     gated;
	} pidc_rsp_t;

	// configuration register contents
	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic [LIMIT_W-1:0]       integral_limit;
		logic [LIMIT_W-1:0]       output_limit;
		logic [GATE_W-1:0]        error_gate;
	} pidc_cfg_t;

endpackage

// ===== rtl/pid_controller_clamped.sv =====
// clamped positional pid controller, top level
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------
//   request  | req_valid / req_stall  | req (cmd, measured, target)
//   result   | rsp_valid / rsp_stall  | rsp (drive, gated)
//   config   | cfg_we                 | cfg_index, cfg_wdata
//
// one item per cycle sustained while the result channel is not stalled; a request passes through
// the error stage, the multiplier stage and the integrator/clamp stage into the result register
// each stage holds only while the one after it is full and stalled, so bubbles close up
// arst_n clears the valid flags, the integrator and the previous error, and resets the config registers
module pid_controller_clamped #(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  pidc_pkg::pidc_req_t              req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output pidc_pkg::pidc_rsp_t              rsp,
	input  logic                             cfg_we,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pidc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int ERR_W   = pidc_pkg::ERR_W;
	localparam int DERR_W  = pidc_pkg::DERR_W;
	localparam int PROD_W  = pidc_pkg::PROD_W;
	localparam int DPROD_W = pidc_pkg::DPROD_W;
	// integrator holds limit << frac plus a sign bit
	localparam int IW      = pidc_pkg::LIMIT_W + GAIN_FRAC_BITS + 1;
	localparam int JW      = ((IW > PROD_W) ? IW : PROD_W) + 1;
	localparam int SW      = ((IW > DPROD_W) ? IW : DPROD_W) + 2;

	pidc_pkg::pidc_cfg_t cfg;

	pidc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// stage registers
	logic                      v_s1, cmd_s1, gated_s1;
	logic signed [ERR_W-1:0]   err_s1;
	logic signed [DERR_W-1:0]  derr_s1;
	logic                      v_s2, cmd_s2, gated_s2;
	logic signed [PROD_W-1:0]  p_s2, i_s2;
	logic signed [DPROD_W-1:0] d_s2;
	logic                      rsp_valid_q;
	pidc_pkg::pidc_rsp_t       rsp_q;
	logic signed [ERR_W-1:0]   prev_err_q;
	logic signed [IW-1:0]      integ_q;

	// stage enables
	logic en_out, en_s2, en_s1, req_accept;

	assign en_out     = !rsp_valid_q || !rsp_stall;
	assign en_s2      = !v_s2 || en_out;
	assign en_s1      = !v_s1 || en_s2;
	assign req_stall  = !en_s1;
	assign req_accept = req_valid && en_s1;

	// error, its magnitude, gate test and difference to the last error
	logic signed [ERR_W-1:0]  err;
	logic [ERR_W-1:0]         err_mag;
	logic                     gate_hit;
	logic signed [DERR_W-1:0] derr;

	assign err      = ERR_W'(req.target) - ERR_W'(req.measured);
	assign err_mag  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
	assign gate_hit = (cfg.error_gate != '0) && (err_mag > ERR_W'(cfg.error_gate));
	assign derr     = DERR_W'(err) - DERR_W'(prev_err_q);

	// error stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			prev_err_q <= '0;
		end else begin
			if (en_s1) begin
				v_s1 <= req_valid;
			end
			if (req_accept && req.cmd == pidc_pkg::CMD_STEP) begin
				prev_err_q <= err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			cmd_s1   <= req.cmd;
			gated_s1 <= gate_hit;
			err_s1   <= err;
			derr_s1  <= derr;
		end
	end

	// multiplier stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			cmd_s2   <= cmd_s1;
			gated_s2 <= gated_s1;
			p_s2     <= PROD_W'(cfg.gain_p) * PROD_W'(err_s1);
			i_s2     <= PROD_W'(cfg.gain_i) * PROD_W'(err_s1);
			d_s2     <= DPROD_W'(cfg.gain_d) * DPROD_W'(derr_s1);
		end
	end

	// integrator accumulate and clamp
	logic signed [JW-1:0] integ_sum, ilim;
	logic signed [IW-1:0] integ_next;

	assign integ_sum = JW'(integ_q) + JW'(i_s2);
	assign ilim      = JW'(cfg.integral_limit) << GAIN_FRAC_BITS;

	always_comb begin
		if (integ_sum > ilim) begin
			integ_next = IW'(ilim);
		end else if (integ_sum < -ilim) begin
			integ_next = IW'(-ilim);
		end else begin
			integ_next = IW'(integ_sum);
		end
	end

	// term sum, floor shift and output clamp
	logic signed [SW-1:0] term_sum, shifted, olim, clamped;

	assign term_sum = SW'(p_s2) + SW'(integ_next) + SW'(d_s2);
	assign shifted  = term_sum >>> GAIN_FRAC_BITS;
	assign olim     = SW'(cfg.output_limit);

	always_comb begin
		if (shifted > olim) begin
			clamped = olim;
		end else if (shifted < -olim) begin
			clamped = -olim;
		end else begin
			clamped = shifted;
		end
	end

	// result register and integrator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			integ_q     <= '0;
		end else begin
			if (en_out) begin
				rsp_valid_q <= v_s2;
			end
			if (en_out && v_s2) begin
				if (cmd_s2 == pidc_pkg::CMD_CLEAR) begin
					integ_q <= '0;
				end else if (!gated_s2) begin
					integ_q <= integ_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			if (cmd_s2 == pidc_pkg::CMD_CLEAR || gated_s2) begin
				rsp_q.drive <= '0;
			end else begin
				rsp_q.drive <= clamped[pidc_pkg::DATA_W-1:0];
			end
			rsp_q.gated <= (cmd_s2 == pidc_pkg::CMD_STEP) && gated_s2;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/pidc_cfg_regs.sv =====
// configuration register file of the pid controller
module pidc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pidc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output pidc_pkg::pidc_cfg_t              cfg
);

	pidc_pkg::pidc_cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p         <= '0;
			cfg_q.gain_i         <= '0;
			cfg_q.gain_d         <= '0;
			cfg_q.integral_limit <= '1;
			cfg_q.output_limit   <= '1;
			cfg_q.error_gate     <= '0;
		end else if (cfg_we) begin
			case (pidc_pkg::reg_idx_t'(cfg_index))
				pidc_pkg::REG_GAIN_P: begin
					cfg_q.gain_p <= cfg_wdata[pidc_pkg::GAIN_W-1:0];
				end
				pidc_pkg::REG_GAIN_I: begin
					cfg_q.gain_i <= cfg_wdata[pidc_pkg::GAIN_W-1:0];
				end
				pidc_pkg::REG_GAIN_D: begin
					cfg_q.gain_d <= cfg_wdata[pidc_pkg::GAIN_W-1:0];
				end
				pidc_pkg::REG_INTEGRAL_LIMIT: begin
					cfg_q.integral_limit <= cfg_wdata[pidc_pkg::LIMIT_W-1:0];
				end
				pidc_pkg::REG_OUTPUT_LIMIT: begin
					cfg_q.output_limit <= cfg_wdata[pidc_pkg::LIMIT_W-1:0];
				end
				pidc_pkg::REG_ERROR_GATE: begin
					cfg_q.error_gate <= cfg_wdata[pidc_pkg::GATE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/pidc_checker.sv =====
// port-level checks for the clamped pid controller
module pidc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input pidc_pkg::pidc_rsp_t rsp
);

	// a suppressed step drives nothing
	a_gated_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.gated |-> rsp.drive == '0)
		else $error("gated item with nonzero drive");

	// the clamp can never reach the most negative code
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.drive != 16'sh8000)
		else $error("drive outside the clamp range");

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ===== tb/tb_top.sv =====
// testbench for the clamped pid controller: random stimulus, predicted drive, in-order checking
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pidc_pkg::*;

	localparam int CLK_HALF    = 5;
	localparam int FRAC        = 8;
	localparam int RESET_LEN   = 12;
	localparam int PIPE_DEPTH  = 3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 225;

	// indexes past the register list, writes there are dropped
	localparam logic [CFG_IDX_W-1:0] IDX_PAST_END = REG_ERROR_GATE + 1'b1;
	localparam logic [CFG_IDX_W-1:0] IDX_LAST     = '1;

	// tracks gains, limits and loop state; holds the drive values still owed by the block
	class pid_tracker;
		logic signed [GAIN_W-1:0] kp, ki, kd;
		logic [LIMIT_W-1:0]       int_lim, out_lim;
		logic [GATE_W-1:0]        gate;
		longint                   prev_error, integ;
		pidc_rsp_t                drive_expected[$];
		int                       mismatches;
		int                       results_seen;

		function new();
			kp = '0;
			ki = '0;
			kd = '0;
			int_lim = '1;
			out_lim = '1;
			gate = '0;
			prev_error = 0;
			integ = 0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_GAIN_P:         kp = val;
				REG_GAIN_I:         ki = val;
				REG_GAIN_D:         kd = val;
				REG_INTEGRAL_LIMIT: int_lim = val[LIMIT_W-1:0];
				REG_OUTPUT_LIMIT:   out_lim = val[LIMIT_W-1:0];
				REG_ERROR_GATE:     gate = val[GATE_W-1:0];
				default: ;
			endcase
		endfunction

		static function longint clamp_sym(longint x, longint lim);
			if (x > lim)
				return lim;
			if (x < -lim)
				return -lim;
			return x;
		endfunction

		// advance the loop state by one accepted item and queue its drive
		function void take_sample(pidc_req_t item);
			longint    err, mag, sum;
			pidc_rsp_t want;
			want = '0;
			if (item.cmd == CMD_CLEAR) begin
				integ = 0;
			end else begin
				err = longint'($signed(item.target)) - longint'($signed(item.measured));
				mag = (err < 0) ? -err : err;
				if (gate != 0 && mag > longint'(gate)) begin
					want.gated = 1'b1;
				end else begin
					integ = clamp_sym(integ + longint'(ki) * err, longint'(int_lim) <<< FRAC);
					sum = longint'(kp) * err + integ + longint'(kd) * (err - prev_error);
					want.drive = 16'(clamp_sym(sum >>> FRAC, longint'(out_lim)));
				end
				prev_error = err;
			end
			drive_expected.push_back(want);
		endfunction

		task flag_mismatch(string msg);
			mismatches++;
			$display("ERROR: %s", msg);
		endtask

		// compare one accepted result with the oldest queued drive
		task match_drive(pidc_rsp_t got);
			pidc_rsp_t want;
			results_seen++;
			if (drive_expected.size() == 0) begin
				flag_mismatch($sformatf("result %0d arrived with nothing owed: drive %0d gated %0b",
					results_seen, $signed(got.drive), got.gated));
				return;
			end
			want = drive_expected.pop_front();
			if (got.drive !== want.drive)
				flag_mismatch($sformatf("result %0d drive %0d, predicted %0d",
					results_seen, $signed(got.drive), $signed(want.drive)));
			if (got.gated !== want.gated)
				flag_mismatch($sformatf("result %0d gated %0b, predicted %0b",
					results_seen, got.gated, want.gated));
		endtask

		function int pending();
			return drive_expected.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	pidc_req_t             req;
	logic                  rsp_valid;
	logic                  rsp_stall;
	pidc_rsp_t             rsp;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	logic send_idle;
	logic stall_on;
	int   stall_left;
	int   cycle_count;

	pid_tracker tracker = new();

	pid_controller_clamped #(
		.GAIN_FRAC_BITS(FRAC)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #CLK_HALF clk = ~clk;

	// receiver stalls in bursts of random length
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (stall_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 9);
		rsp_stall <= (stall_left > 0);
	end

	// collect accepted results
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			tracker.match_drive(rsp);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic pidc_req_t make_item(logic cmd, int meas, int tgt);
		pidc_req_t it;
		it.cmd = cmd;
		it.measured = 16'(meas);
		it.target = 16'(tgt);
		return it;
	endfunction

	// mostly tracking around a set point with a bias, some fully random items and clears
	function automatic pidc_req_t rand_item(logic [DATA_W-1:0] setpoint, int bias);
		pidc_req_t it;
		int        off;
		it.cmd = ($urandom_range(0, 24) == 0) ? CMD_CLEAR : CMD_STEP;
		if ($urandom_range(0, 3) == 0) begin
			it.measured = 16'($urandom);
			it.target = 16'($urandom);
		end else begin
			off = bias + int'($urandom_range(0, 600)) - 300;
			it.target = setpoint;
			it.measured = 16'(int'($signed(setpoint)) + off);
		end
		return it;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_gain();
		case ($urandom_range(0, 7))
			0:       return 16'h7fff;
			1:       return 16'h8000;
			2, 3:    return 16'($urandom);
			4, 5:    return 16'(-int'($urandom_range(0, 512)));
			default: return 16'($urandom_range(0, 512));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_limit();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return 16'hffff;
			2:       return 16'($urandom);
			default: return 16'($urandom_range(1, 4000));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_gate();
		case ($urandom_range(0, 4))
			0, 1:    return '0;
			2:       return 16'($urandom);
			default: return 16'($urandom_range(1, 2000));
		endcase
	endfunction

	// present one item, with an optional gap first, and hold it until accepted
	task automatic send_item(pidc_req_t item);
		int gap;
		if (send_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		tracker.take_sample(item);
	endtask

	// stop sending and wait until every owed result is back
	task automatic settle();
		req_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 1) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		tracker.write_reg(idx, val);
	endtask

	task automatic apply_config(logic [CFG_DATA_W-1:0] kp, logic [CFG_DATA_W-1:0] ki,
			logic [CFG_DATA_W-1:0] kd, logic [CFG_DATA_W-1:0] ilim,
			logic [CFG_DATA_W-1:0] olim, logic [CFG_DATA_W-1:0] gate);
		cfg_write(REG_GAIN_P, kp);
		cfg_write(REG_GAIN_I, ki);
		cfg_write(REG_GAIN_D, kd);
		cfg_write(REG_INTEGRAL_LIMIT, ilim);
		cfg_write(REG_OUTPUT_LIMIT, olim);
		cfg_write(REG_ERROR_GATE, gate);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [DATA_W-1:0] setpoint;
		int                bias;

		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		rsp_stall <= 1'b0;
		send_idle <= 1'b1;
		stall_on <= 1'b1;
		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset values: all gains zero
		send_item(make_item(CMD_STEP, 100, -100));
		send_item(make_item(CMD_STEP, 32767, -32768));
		settle();

		// plain regulation, error extremes, clear command
		apply_config(16'd256, 16'd32, 16'd128, 16'd50, 16'd1000, 16'd0);
		send_item(make_item(CMD_STEP, 0, 0));
		send_item(make_item(CMD_STEP, -32768, 32767));
		send_item(make_item(CMD_STEP, 32767, -32768));
		send_item(make_item(CMD_STEP, 10, 20));
		send_item(make_item(CMD_STEP, 10, 20));
		send_item(make_item(CMD_STEP, 10, 20));
		send_item(make_item(CMD_CLEAR, 0, 0));
		send_item(make_item(CMD_STEP, 5, -5));
		send_item(make_item(CMD_CLEAR, -32768, 32767));
		settle();

		// gated steps around the threshold, both signs
		apply_config(16'd256, 16'd64, 16'd256, 16'd2000, 16'd5000, 16'd100);
		send_item(make_item(CMD_STEP, 0, 101));
		send_item(make_item(CMD_STEP, 0, 100));
		send_item(make_item(CMD_STEP, 100, 0));
		send_item(make_item(CMD_STEP, 0, -101));
		send_item(make_item(CMD_STEP, 50, 60));
		settle();

		// zero limits force integrator and drive to zero
		apply_config(16'd512, 16'd256, 16'd256, 16'd0, 16'd0, 16'd0);
		send_item(make_item(CMD_STEP, 0, 500));
		send_item(make_item(CMD_STEP, -300, 300));
		settle();

		// extreme gains, upper bits of limit writes, widest gate, writes past the list
		apply_config(16'h8000, 16'h7fff, 16'h8000, 16'hffff, 16'hffff, 16'hffff);
		cfg_write(IDX_PAST_END, 16'h1234);
		cfg_write(IDX_LAST, 16'h0000);
		cfg_we <= 1'b0;
		@(posedge clk);
		send_item(make_item(CMD_STEP, -32768, 32767));
		send_item(make_item(CMD_STEP, 32767, -32768));
		send_item(make_item(CMD_STEP, 0, 0));
		send_item(make_item(CMD_STEP, 1, 0));
		send_item(make_item(CMD_STEP, -1, -1));
		settle();

		// random phases, last one with no idling on either side
		for (int ph = 0; ph < PHASES; ph++) begin
			send_idle <= (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
			stall_on <= (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
			apply_config(rand_gain(), rand_gain(), rand_gain(), rand_limit(), rand_limit(),
				rand_gate());
			setpoint = 16'($urandom);
			bias = int'($urandom_range(0, 400)) - 200;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// hold off mid-phase until the pipeline drains
				if (ph == 3 && n == PHASE_ITEMS / 2)
					settle();
				send_item(rand_item(setpoint, bias));
			end
			settle();
		end

		repeat (2 * PIPE_DEPTH + 2) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
